// File: sv/cpps_pkg.sv
// cpps_pkg: shared types, constants and register map for the capture period PI servo.
// No dependencies; imported by every cpps_* module and the top level.
`timescale 1ns / 1ps

package cpps_pkg;

    // Default values for top-level parameters
    localparam int STAMP_BITS_DFLT = 32;
    localparam int GAIN_FRAC_DFLT  = 16;

    // Fixed field widths
    localparam int DUTY_BITS     = 12;
    localparam int CFG_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // Command codes
    localparam logic [1:0] OP_CAPTURE = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_RESYNC  = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TARGET      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_MIN_PERIOD  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_CENTER = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_MIN    = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_MAX    = 3'd7;

    // Reset values
    localparam logic [31:0]          PROP_GAIN_RST   = 32'd65536;
    localparam logic [31:0]          INTEG_GAIN_RST  = 32'd655;
    localparam logic [30:0]          TARGET_RST      = 31'd25600;
    localparam logic [31:0]          MIN_PERIOD_RST  = 32'd6400;
    localparam logic [30:0]          INTEG_LIMIT_RST = 31'd1048576;
    localparam logic [DUTY_BITS-1:0] DUTY_CENTER_RST = DUTY_BITS'(2048);
    localparam logic [DUTY_BITS-1:0] DUTY_MIN_RST    = '0;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX_RST    = '1;

    typedef struct packed {
        logic signed [31:0]    prop_gain;
        logic signed [31:0]    integ_gain;
        logic [30:0]           period_setpoint;
        logic [31:0]           min_period;
        logic [30:0]           integ_limit;
        logic [DUTY_BITS-1:0]  duty_center;
        logic [DUTY_BITS-1:0]  duty_min;
        logic [DUTY_BITS-1:0]  duty_max;
    } cpps_cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] timestamp;
    } cpps_in_t;

    typedef struct packed {
        logic [31:0]          period_ticks;
        logic signed [31:0]   speed_error;
        logic signed [31:0]   integ_value;
        logic [DUTY_BITS-1:0] duty;
    } cpps_out_t;

    // Measurement stage: period, saturated error, clamped integral
    typedef struct packed {
        logic [31:0]        period;
        logic signed [31:0] err;
        logic signed [31:0] acc;
    } cpps_meas_t;

endpackage

// File: sv/capture_period_pi_servo_unit.sv
// capture_period_pi_servo_unit: top level of the period-measuring PI speed servo.
// Instantiates cpps_regs, cpps_integ and cpps_duty; depends on cpps_pkg.
`timescale 1ns / 1ps
// Usage
//   capture channel (capture_valid / capture_stall / capture): one command per
//   transfer. OP_CAPTURE carries an edge timestamp, OP_CLEAR zeroes the
//   integral, OP_RESYNC reseeds the stored timestamp. Only a capture whose
//   period reaches min_period yields a result; other transfers only update state.
//   result channel (result_valid / result_stall / result): period, saturated
//   error, clamped integral and new duty.
//   APB port: eight 32-bit registers at byte addresses 0x00..0x1C; write only
//   while no command is in flight.
// Timing
//   Four register stages: input, measurement/integral, products, result.
//   One command per cycle is taken while the result is not stalled; the
//   integral and timestamp loop closes within the measurement stage, so
//   back-to-back captures see each other's state.
// Reset
//   Registers return to their defaults, stored timestamp and integral to zero,
//   all stages empty.
// Stall
//   A stalled result freezes the whole pipeline; capture_stall rises in the
//   same cycle and the result payload holds until it is taken.
module capture_period_pi_servo_unit #(
    parameter int STAMP_BITS     = cpps_pkg::STAMP_BITS_DFLT,
    parameter int GAIN_FRAC_BITS = cpps_pkg::GAIN_FRAC_DFLT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command input
    input  logic                                capture_valid,
    output logic                                capture_stall,
    input  cpps_pkg::cpps_in_t                  capture,
    // result output
    output logic                                result_valid,
    input  logic                                result_stall,
    output cpps_pkg::cpps_out_t                 result,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cpps_pkg::*;

    cpps_cfg_t  cfg;
    logic       adv;
    logic       item_valid_reg;
    cpps_in_t   item_reg;
    logic       meas_valid;
    cpps_meas_t meas;

    // whole pipeline moves unless a finished result is held off
    assign adv           = !result_valid || !result_stall;
    assign capture_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            item_valid_reg <= capture_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && capture_valid)
        begin
            item_reg <= capture;
        end
    end

    cpps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpps_integ #(
        .STAMP_BITS (STAMP_BITS)
    ) u_integ (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .meas_valid (meas_valid),
        .meas       (meas)
    );

    cpps_duty #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_duty (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg          (cfg),
        .meas_valid   (meas_valid),
        .meas         (meas),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: sv/cpps_regs.sv
// cpps_regs: APB-style configuration register file.
// Depends on cpps_pkg (cpps_cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module cpps_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output cpps_pkg::cpps_cfg_t                 cfg
);
    import cpps_pkg::*;

    cpps_cfg_t                cfg_reg;
    logic                     wr_en;
    logic [REG_IDX_BITS-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.integ_gain      <= INTEG_GAIN_RST;
            cfg_reg.period_setpoint <= TARGET_RST;
            cfg_reg.min_period      <= MIN_PERIOD_RST;
            cfg_reg.integ_limit     <= INTEG_LIMIT_RST;
            cfg_reg.duty_center     <= DUTY_CENTER_RST;
            cfg_reg.duty_min        <= DUTY_MIN_RST;
            cfg_reg.duty_max        <= DUTY_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PROP_GAIN:   cfg_reg.prop_gain       <= pwdata;
                REG_INTEG_GAIN:  cfg_reg.integ_gain      <= pwdata;
                REG_TARGET:      cfg_reg.period_setpoint <= pwdata[30:0];
                REG_MIN_PERIOD:  cfg_reg.min_period      <= pwdata;
                REG_INTEG_LIMIT: cfg_reg.integ_limit     <= pwdata[30:0];
                REG_DUTY_CENTER: cfg_reg.duty_center     <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_MIN:    cfg_reg.duty_min        <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_MAX:    cfg_reg.duty_max        <= pwdata[DUTY_BITS-1:0];
                default:         cfg_reg.prop_gain       <= cfg_reg.prop_gain;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:   prdata = cfg_reg.prop_gain;
            REG_INTEG_GAIN:  prdata = cfg_reg.integ_gain;
            REG_TARGET:      prdata = 32'(cfg_reg.period_setpoint);
            REG_MIN_PERIOD:  prdata = cfg_reg.min_period;
            REG_INTEG_LIMIT: prdata = 32'(cfg_reg.integ_limit);
            REG_DUTY_CENTER: prdata = 32'(cfg_reg.duty_center);
            REG_DUTY_MIN:    prdata = 32'(cfg_reg.duty_min);
            REG_DUTY_MAX:    prdata = 32'(cfg_reg.duty_max);
            default:         prdata = '0;
        endcase
    end

endmodule

// File: sv/cpps_integ.sv
// cpps_integ: period measurement, error saturation and integral clamp.
// Holds prev_stamp and the integral; depends on cpps_pkg.
`timescale 1ns / 1ps

module cpps_integ #(
    parameter int STAMP_BITS = cpps_pkg::STAMP_BITS_DFLT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  cpps_pkg::cpps_cfg_t   cfg,
    input  logic                  item_valid,
    input  cpps_pkg::cpps_in_t    item,
    output logic                  meas_valid,
    output cpps_pkg::cpps_meas_t  meas
);
    import cpps_pkg::*;

    localparam logic signed [33:0] ERR_MAX = 34'sd2147483647;

    logic [STAMP_BITS-1:0] prev_stamp_reg, prev_stamp_next;
    logic signed [31:0]    integ_acc_reg, integ_acc_next;
    logic                  meas_valid_reg, meas_valid_next;
    cpps_meas_t            meas_reg, meas_next;

    logic [STAMP_BITS-1:0] now;
    logic [STAMP_BITS-1:0] delta;
    logic [31:0]           period;
    logic signed [33:0]    diff;
    logic signed [31:0]    err;
    logic signed [32:0]    sum;
    logic signed [32:0]    lim_pos;
    logic signed [32:0]    lim_neg;
    logic signed [32:0]    acc_w;

    always_comb
    begin
        now     = item.timestamp[STAMP_BITS-1:0];
        delta   = now - prev_stamp_reg;
        period  = 32'(delta);
        diff    = $signed({2'b00, period}) - $signed({3'b000, cfg.period_setpoint});
        // only the upper bound can be exceeded
        err     = (diff > ERR_MAX) ? 32'sh7FFFFFFF : diff[31:0];
        sum     = 33'(integ_acc_reg) + 33'(err);
        lim_pos = $signed({2'b00, cfg.integ_limit});
        lim_neg = -lim_pos;
        acc_w   = sum;
        if (acc_w < lim_neg)
        begin
            acc_w = lim_neg;
        end
        if (acc_w > lim_pos)
        begin
            acc_w = lim_pos;
        end

        prev_stamp_next  = prev_stamp_reg;
        integ_acc_next   = integ_acc_reg;
        meas_valid_next  = 1'b0;
        meas_next.period = period;
        meas_next.err    = err;
        meas_next.acc    = acc_w[31:0];

        if (item_valid)
        begin
            unique case (item.operation)
                OP_CAPTURE:
                begin
                    prev_stamp_next = now;
                    if (period >= cfg.min_period)
                    begin
                        integ_acc_next  = acc_w[31:0];
                        meas_valid_next = 1'b1;
                    end
                end
                OP_CLEAR:  integ_acc_next  = '0;
                OP_RESYNC: prev_stamp_next = now;
                default:   meas_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_stamp_reg <= '0;
            integ_acc_reg  <= '0;
            meas_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prev_stamp_reg <= prev_stamp_next;
            integ_acc_reg  <= integ_acc_next;
            meas_valid_reg <= meas_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && meas_valid_next)
        begin
            meas_reg <= meas_next;
        end
    end

    assign meas_valid = meas_valid_reg;
    assign meas       = meas_reg;

endmodule

// File: sv/cpps_duty.sv
// cpps_duty: Q-format P and I products, then duty sum and clamp into the result register.
// Depends on cpps_pkg (cpps_cfg_t, cpps_meas_t, cpps_out_t).
`timescale 1ns / 1ps

module cpps_duty #(
    parameter int GAIN_FRAC_BITS = cpps_pkg::GAIN_FRAC_DFLT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  cpps_pkg::cpps_cfg_t   cfg,
    input  logic                  meas_valid,
    input  cpps_pkg::cpps_meas_t  meas,
    output logic                  result_valid,
    output cpps_pkg::cpps_out_t   result
);
    import cpps_pkg::*;

    localparam int SUM_W = 66;

    // product stage
    logic               prod_valid_reg;
    cpps_meas_t         prod_meas_reg;
    logic signed [63:0] p_prod_reg, p_prod_next;
    logic signed [63:0] i_prod_reg, i_prod_next;

    // result stage
    logic               result_valid_reg;
    cpps_out_t          result_reg, result_next;

    logic signed [63:0]    p_term;
    logic signed [63:0]    i_term;
    logic signed [SUM_W-1:0] duty_w;
    logic signed [SUM_W-1:0] dmin_w;
    logic signed [SUM_W-1:0] dmax_w;
    logic signed [SUM_W-1:0] center_w;

    always_comb
    begin
        p_prod_next = cfg.prop_gain * meas.err;
        i_prod_next = cfg.integ_gain * meas.acc;
    end

    always_comb
    begin
        p_term   = p_prod_reg >>> GAIN_FRAC_BITS;
        i_term   = i_prod_reg >>> GAIN_FRAC_BITS;
        center_w = $signed(SUM_W'(cfg.duty_center));
        dmin_w   = $signed(SUM_W'(cfg.duty_min));
        dmax_w   = $signed(SUM_W'(cfg.duty_max));
        duty_w   = center_w - SUM_W'(p_term) - SUM_W'(i_term);
        // min first, then max: an inverted range yields duty_max
        if (duty_w < dmin_w)
        begin
            duty_w = dmin_w;
        end
        if (duty_w > dmax_w)
        begin
            duty_w = dmax_w;
        end
        result_next.period_ticks = prod_meas_reg.period;
        result_next.speed_error  = prod_meas_reg.err;
        result_next.integ_value  = prod_meas_reg.acc;
        result_next.duty         = duty_w[DUTY_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg   <= meas_valid;
            result_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && meas_valid)
        begin
            prod_meas_reg <= meas;
            p_prod_reg    <= p_prod_next;
            i_prod_reg    <= i_prod_next;
        end
        if (adv && prod_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
